FILE: src/lsac_pkg.sv
package lsac_pkg;

  // Array geometry
  localparam int NUM_CHANNELS = 8;
  localparam int SAMPLE_W     = 8;
  localparam int SAMPLES_W    = NUM_CHANNELS * SAMPLE_W;
  localparam int CNT_W        = $clog2(NUM_CHANNELS + 1);

  // Result field widths and packing
  localparam int DARK_COUNT_W  = 4;
  localparam int OUT_FIELDS_W  = NUM_CHANNELS + DARK_COUNT_W + 2;
  localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CMP_W         = CNT_W + 4;

  // Configuration registers
  localparam int CAL_FRAMES_W = 8;
  localparam int MAJORITY_W   = 4;
  localparam int CFG_DATA_W   = 8;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_CAL_FRAMES = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAJORITY   = 1'd1;

  localparam logic [CAL_FRAMES_W-1:0] CAL_FRAMES_RST = 8'd100;
  localparam logic [MAJORITY_W-1:0]   MAJORITY_RST   = 4'd4;

  // Per-channel reset values
  localparam logic [SAMPLE_W-1:0] PEAK_RST  = 8'd230;
  localparam logic [SAMPLE_W-1:0] FLOOR_RST = 8'd5;
  localparam logic [SAMPLE_W-1:0] THR_RST   = 8'd117;
  localparam logic [SAMPLE_W-1:0] MAX_RST   = 8'd0;
  localparam logic [SAMPLE_W-1:0] MIN_RST   = 8'd255;

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_BLACK = 2'd1,
    CMD_WHITE = 2'd2,
    CMD_APPLY = 2'd3
  } cmd_t;

  // One beat as it travels down the row of cells
  typedef struct packed {
    logic                    vld;
    cmd_t                    cmd;
    logic                    commit;
    logic [SAMPLES_W-1:0]    samples;
    logic [NUM_CHANNELS-1:0] bits;
    logic [CNT_W-1:0]        count;
  } lsac_beat_t;

endpackage

FILE: src/lsac_cell.sv
module lsac_cell
  import lsac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  lsac_beat_t beat_i,
  output lsac_beat_t beat_o
);

  logic [SAMPLE_W-1:0] thr_r, thr_nxt;
  logic [SAMPLE_W-1:0] peak_r, peak_nxt;
  logic [SAMPLE_W-1:0] floor_r, floor_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  lsac_beat_t          beat_r, beat_nxt;

  logic [SAMPLE_W-1:0]           smp;
  logic                          dark;
  logic [SAMPLE_W-1:0]           hi;
  logic [SAMPLE_W-1:0]           lo;
  logic [SAMPLE_W:0]             mid_sum;
  logic [SAMPLES_W+SAMPLE_W-1:0] smp_ext;
  logic [NUM_CHANNELS:0]         bits_ext;

  // This cell always works on the lowest sample of the beat
  assign smp      = beat_i.samples[SAMPLE_W-1:0];
  assign dark     = (beat_i.cmd == CMD_SCAN) && (smp > thr_r);
  assign hi       = (smp > max_r) ? smp : max_r;
  assign lo       = (smp < min_r) ? smp : min_r;
  assign mid_sum  = {1'b0, peak_r} + {1'b0, floor_r};
  assign smp_ext  = {{SAMPLE_W{1'b0}}, beat_i.samples};
  assign bits_ext = {dark, beat_i.bits};

  // Beat handed to the next cell: samples move down, the decision enters at the top
  always_comb begin
    beat_nxt         = beat_i;
    beat_nxt.samples = smp_ext[SAMPLES_W+SAMPLE_W-1:SAMPLE_W];
    beat_nxt.bits    = bits_ext[NUM_CHANNELS:1];
    beat_nxt.count   = beat_i.count + CNT_W'(dark);
  end

  // Channel state update for the beat passing through
  always_comb begin
    thr_nxt   = thr_r;
    peak_nxt  = peak_r;
    floor_nxt = floor_r;
    max_nxt   = max_r;
    min_nxt   = min_r;
    if (beat_i.vld) begin
      case (beat_i.cmd)
        CMD_BLACK: begin
          if (beat_i.commit) begin
            peak_nxt = hi;
            max_nxt  = MAX_RST;
          end else begin
            max_nxt  = hi;
          end
        end
        CMD_WHITE: begin
          if (beat_i.commit) begin
            floor_nxt = lo;
            min_nxt   = MIN_RST;
          end else begin
            min_nxt   = lo;
          end
        end
        CMD_APPLY: begin
          thr_nxt = mid_sum[SAMPLE_W:1];
        end
        default: begin
          thr_nxt = thr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RST;
      peak_r     <= PEAK_RST;
      floor_r    <= FLOOR_RST;
      max_r      <= MAX_RST;
      min_r      <= MIN_RST;
      beat_r.vld <= 1'b0;
    end else if (adv) begin
      thr_r   <= thr_nxt;
      peak_r  <= peak_nxt;
      floor_r <= floor_nxt;
      max_r   <= max_nxt;
      min_r   <= min_nxt;
      beat_r  <= beat_nxt;
    end
  end

  assign beat_o = beat_r;

  // A commit flag only ever rides on a calibration frame
  a_commit_cal : assert property (@(posedge clk) disable iff (!rst_n)
    (beat_r.vld && beat_r.commit) |-> (beat_r.cmd == CMD_BLACK || beat_r.cmd == CMD_WHITE))
    else $error("commit on a non-calibration beat");

endmodule

FILE: src/lsac_run_ctrl.sv
module lsac_run_ctrl
  import lsac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  cmd_t                    cmd,
  input  logic [CAL_FRAMES_W-1:0] cal_frames,
  output logic                    commit
);

  logic [CAL_FRAMES_W-1:0] dark_seen_r, dark_seen_nxt;
  logic [CAL_FRAMES_W-1:0] light_seen_r, light_seen_nxt;
  logic [CAL_FRAMES_W-1:0] dark_inc;
  logic [CAL_FRAMES_W-1:0] light_inc;
  logic                    dark_full;
  logic                    light_full;

  assign dark_inc   = dark_seen_r + CAL_FRAMES_W'(1'b1);
  assign light_inc  = light_seen_r + CAL_FRAMES_W'(1'b1);
  assign dark_full  = dark_inc >= cal_frames;
  assign light_full = light_inc >= cal_frames;

  // Run length bookkeeping for the frame about to enter the row
  always_comb begin
    commit         = 1'b0;
    dark_seen_nxt  = dark_seen_r;
    light_seen_nxt = light_seen_r;
    case (cmd)
      CMD_BLACK: begin
        commit        = dark_full;
        dark_seen_nxt = dark_full ? '0 : dark_inc;
      end
      CMD_WHITE: begin
        commit         = light_full;
        light_seen_nxt = light_full ? '0 : light_inc;
      end
      default: begin
        commit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_seen_r  <= '0;
      light_seen_r <= '0;
    end else if (accept) begin
      dark_seen_r  <= dark_seen_nxt;
      light_seen_r <= light_seen_nxt;
    end
  end

  // A committing black frame restarts the black run
  a_dark_restart : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_BLACK && commit) |=> (dark_seen_r == '0))
    else $error("black run did not restart after commit");

endmodule

FILE: src/line_sensor_array_classifier_core.sv
// Line sensor array classifier.
// Input beats arrive on in_tvalid/in_tready: in_tuser carries the command (scan,
// black calibration, white calibration, apply thresholds) and in_tdata the eight
// 8-bit reflectance samples, channel 0 in the lowest byte. Every input beat gives
// exactly one result beat on out_tvalid/out_tready. The samples walk down a row
// of identical cells, one cell per channel, each holding that channel's threshold,
// committed peak and floor, and running max and min. A new beat is taken on every
// cycle unless the output stalls; the result passes through the cell registers,
// then the output register. The majority test and inversion are done as the beat
// enters the output register. When the receiver stalls a full output register, the
// whole row freezes and in_tready drops in the same cycle; nothing is lost or
// repeated. Configuration is written on cfg_wr_en with cfg_addr 0 for the
// calibration run length and 1 for the majority level; the user must write it
// only while no beat is in flight, which the block does not enforce. Reset leaves
// thresholds at 117, peaks at 230, floors at 5, run counters cleared, run length
// 100 and majority level 4; the block is ready the cycle after reset.
module line_sensor_array_classifier_core
  import lsac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLES_W-1:0]  in_tdata,  // sample_0 .. sample_7, 8 bits each
  input  logic [1:0]            in_tuser,  // cmd
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata  // line_bits, dark_count, white_line,
                                           // calibration_done, zero fill
);

  logic [CAL_FRAMES_W-1:0] cal_frames_r;
  logic [MAJORITY_W-1:0]   majority_r;

  logic       adv;
  logic       accept;
  logic       commit;
  cmd_t       in_cmd;
  lsac_beat_t chain [NUM_CHANNELS+1];
  lsac_beat_t last;

  logic                    out_valid_r;
  logic [NUM_CHANNELS-1:0] line_bits_r, line_bits_nxt;
  logic [DARK_COUNT_W-1:0] dark_count_r, dark_count_nxt;
  logic                    white_r, white_nxt;
  logic                    done_r, done_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_frames_r <= CAL_FRAMES_RST;
      majority_r   <= MAJORITY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_CAL_FRAMES: cal_frames_r <= cfg_wdata[CAL_FRAMES_W-1:0];
        CFG_MAJORITY:   majority_r   <= cfg_wdata[MAJORITY_W-1:0];
        default: begin
          cal_frames_r <= cal_frames_r;
        end
      endcase
    end
  end

  // The row moves whenever the output register is empty or being drained
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && adv;
  assign in_cmd    = cmd_t'(in_tuser);

  lsac_run_ctrl u_run_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (in_cmd),
    .cal_frames (cal_frames_r),
    .commit     (commit)
  );

  // Beat entering the first cell
  always_comb begin
    chain[0].vld     = in_tvalid;
    chain[0].cmd     = in_cmd;
    chain[0].commit  = commit;
    chain[0].samples = in_tdata;
    chain[0].bits    = '0;
    chain[0].count   = '0;
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    lsac_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .beat_i (chain[g]),
      .beat_o (chain[g+1])
    );
  end

  assign last = chain[NUM_CHANNELS];

  // Majority test and inversion for scans, calibration status for the rest
  always_comb begin
    white_nxt      = (last.cmd == CMD_SCAN) && (CMP_W'(last.count) >= CMP_W'(majority_r));
    line_bits_nxt  = white_nxt ? ~last.bits : last.bits;
    dark_count_nxt = DARK_COUNT_W'(last.count);
    done_nxt       = last.commit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      line_bits_r  <= line_bits_nxt;
      dark_count_r <= dark_count_nxt;
      white_r      <= white_nxt;
      done_r       <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({done_r, white_r, dark_count_r, line_bits_r});

  // A white line needs the majority count behind it
  a_white_majority : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && white_r) |-> (CMP_W'(dark_count_r) >= CMP_W'(majority_r)))
    else $error("white line reported below majority level");

  // A finished calibration run never carries scan results
  a_done_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> (line_bits_r == '0 && dark_count_r == '0 && !white_r))
    else $error("calibration result carries scan fields");

  // A stalled output leaves the row and the result frozen
  a_stall_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(line_bits_r) && $stable(done_r) && out_valid_r))
    else $error("result changed under stall");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import lsac_pkg::*;

  // One input beat: command in tuser, eight samples in tdata.
  typedef struct packed {
    cmd_t                 cmd;
    logic [SAMPLES_W-1:0] samples;
  } frame_t;

  // One result beat, laid out as out_tdata carries it from bit 0 up.
  typedef struct packed {
    logic                    cal_done;
    logic                    white;
    logic [DARK_COUNT_W-1:0] dark_count;
    logic [NUM_CHANNELS-1:0] line_bits;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLES_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;  // cmd

  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // line_bits, dark_count, white_line,
                                         // calibration_done, zero fill

  line_sensor_array_classifier_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Frames waiting to be sent, the frame currently offered, and the verdicts
  // still owed by the block.
  frame_t   frame_q[$];
  frame_t   offered;
  verdict_t verdict_q[$];

  int send_idle_pct = 14;
  int recv_idle_pct = 65;
  int mismatch_cnt = 0;

  // Mirror of the block's configuration and per-channel calibration state.
  logic [CAL_FRAMES_W-1:0] run_len;
  logic [MAJORITY_W-1:0]   majority_lvl;
  logic [SAMPLE_W-1:0]     peak_mem [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]     floor_mem [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]     thr_mem [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]     run_max [NUM_CHANNELS];
  logic [SAMPLE_W-1:0]     run_min [NUM_CHANNELS];
  logic [7:0]              dark_seen;
  logic [7:0]              light_seen;

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Work out the verdict for one accepted frame and advance the calibration state.
  task automatic classify_frame(input frame_t f);
    verdict_t v;
    logic [SAMPLE_W-1:0] s;
    v = '0;
    case (f.cmd)
      CMD_SCAN: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          s = f.samples[c*SAMPLE_W +: SAMPLE_W];
          // A sample equal to its threshold still counts as light.
          if (s > thr_mem[c]) begin
            v.dark_count = v.dark_count + DARK_COUNT_W'(1'b1);
            v.line_bits[c] = 1'b1;
          end
        end
        if (v.dark_count >= majority_lvl) begin
          v.line_bits = ~v.line_bits;
          v.white = 1'b1;
        end
      end
      CMD_BLACK: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          s = f.samples[c*SAMPLE_W +: SAMPLE_W];
          if (s > run_max[c]) run_max[c] = s;
        end
        dark_seen = dark_seen + 8'd1;
        if (dark_seen >= run_len) begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            peak_mem[c] = run_max[c];
            run_max[c] = MAX_RST;
          end
          dark_seen = '0;
          v.cal_done = 1'b1;
        end
      end
      CMD_WHITE: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          s = f.samples[c*SAMPLE_W +: SAMPLE_W];
          if (s < run_min[c]) run_min[c] = s;
        end
        light_seen = light_seen + 8'd1;
        if (light_seen >= run_len) begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            floor_mem[c] = run_min[c];
            run_min[c] = MIN_RST;
          end
          light_seen = '0;
          v.cal_done = 1'b1;
        end
      end
      default: begin
        // Apply: midpoint of the last committed peak and floor.
        for (int c = 0; c < NUM_CHANNELS; c++)
          thr_mem[c] = 8'((9'(peak_mem[c]) + 9'(floor_mem[c])) >> 1);
      end
    endcase
    verdict_q.push_back(v);
  endtask

  // Driver: offers queued frames, idling at random between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) classify_frame(offered);
      if (!in_tvalid || in_tready) begin
        if (frame_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = frame_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= offered.samples;
          in_tuser <= offered.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest owed verdict.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(verdict_t)-1:0];
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("result beat %h with nothing expected", out_tdata));
        end else begin
          want = verdict_q.pop_front();
          if (got.line_bits !== want.line_bits)
            note_mismatch($sformatf("line_bits got %h want %h",
                                    got.line_bits, want.line_bits));
          if (got.dark_count !== want.dark_count)
            note_mismatch($sformatf("dark_count got %0d want %0d",
                                    got.dark_count, want.dark_count));
          if (got.white !== want.white)
            note_mismatch($sformatf("white_line got %b want %b", got.white, want.white));
          if (got.cal_done !== want.cal_done)
            note_mismatch($sformatf("calibration_done got %b want %b",
                                    got.cal_done, want.cal_done));
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_frame(input cmd_t c, input logic [SAMPLES_W-1:0] s);
    frame_t f;
    f.cmd = c;
    f.samples = s;
    frame_q.push_back(f);
  endtask

  // Hold off until every queued frame has gone and every verdict has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (frame_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (addr == CFG_CAL_FRAMES) run_len = val;
    else majority_lvl = val[MAJORITY_W-1:0];
  endtask

  // Random frame: scans lean towards the current thresholds, black runs towards
  // dark readings and white runs towards light ones.
  task automatic push_random_frame();
    cmd_t c;
    logic [SAMPLES_W-1:0] s;
    int r;
    int v;
    r = $urandom_range(0, 99);
    c = (r < 50) ? CMD_SCAN : (r < 70) ? CMD_BLACK : (r < 90) ? CMD_WHITE : CMD_APPLY;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      r = $urandom_range(0, 9);
      if (r == 0) v = 0;
      else if (r == 1) v = 255;
      else if (r < 6 && c == CMD_SCAN)
        v = int'(thr_mem[ch]) + int'($urandom_range(0, 2)) - 1;
      else if (r < 7 && c == CMD_BLACK) v = $urandom_range(120, 255);
      else if (r < 7 && c == CMD_WHITE) v = $urandom_range(0, 135);
      else v = $urandom_range(0, 255);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      s[ch*SAMPLE_W +: SAMPLE_W] = v[7:0];
    end
    push_frame(c, s);
  endtask

  // Stimulus and run control.
  initial begin
    int run_tab [9];
    int maj_tab [9];
    int per_phase;
    run_len = CAL_FRAMES_RST;
    majority_lvl = MAJORITY_RST;
    dark_seen = '0;
    light_seen = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      peak_mem[c] = PEAK_RST;
      floor_mem[c] = FLOOR_RST;
      thr_mem[c] = THR_RST;
      run_max[c] = MAX_RST;
      run_min[c] = MIN_RST;
    end
    run_tab = '{255, 1, 7, 0, 2, 0, 3, 0, 100};
    maj_tab = '{8, 0, 3, 15, 5, 0, 4, 9, 0};
    run_tab[5] = $urandom_range(0, 255);
    run_tab[7] = $urandom_range(0, 255);
    maj_tab[5] = $urandom_range(0, 15);
    maj_tab[8] = $urandom_range(0, 15);
    per_phase = 205;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: extremes, the equal-to-threshold case and a majority scan.
    push_frame(CMD_SCAN, {8{8'd0}});
    push_frame(CMD_SCAN, {8{8'd255}});
    push_frame(CMD_SCAN, {8{8'd117}});
    push_frame(CMD_SCAN, {8{8'd118}});
    push_frame(CMD_SCAN, {4{8'd118, 8'd117}});
    push_frame(CMD_BLACK, {8{8'd200}});
    push_frame(CMD_WHITE, {8{8'd20}});
    push_frame(CMD_APPLY, {8{8'hA5}});
    wait_drained();

    // Zero run length commits every calibration frame; zero majority always inverts.
    write_reg(CFG_CAL_FRAMES, 8'd0);
    write_reg(CFG_MAJORITY, 8'd0);
    push_frame(CMD_BLACK, 64'hF0E1_D2C3_B4A5_9687);
    push_frame(CMD_WHITE, 64'h0F1E_2D3C_4B5A_6978);
    push_frame(CMD_APPLY, 64'h0);
    push_frame(CMD_SCAN, 64'h0);
    push_frame(CMD_SCAN, 64'hFFFF_FFFF_FFFF_FFFF);
    wait_drained();

    // Run length lowered part way through a black run; majority above the
    // channel count never inverts.
    write_reg(CFG_CAL_FRAMES, 8'd3);
    write_reg(CFG_MAJORITY, 8'd15);
    push_frame(CMD_BLACK, {8{8'd50}});
    push_frame(CMD_BLACK, {8{8'd90}});
    push_frame(CMD_WHITE, {8{8'd60}});
    wait_drained();
    write_reg(CFG_CAL_FRAMES, 8'd1);
    push_frame(CMD_BLACK, {8{8'd10}});
    push_frame(CMD_WHITE, {8{8'd70}});
    push_frame(CMD_APPLY, 64'h0);
    push_frame(CMD_SCAN, {8{8'd255}});
    wait_drained();
    write_reg(CFG_MAJORITY, 8'd8);
    push_frame(CMD_SCAN, {8{8'd255}});
    push_frame(CMD_SCAN, {8'd0, {7{8'd255}}});
    wait_drained();

    // Random phases under changing settings and idling patterns.
    for (int p = 0; p < 9; p++) begin
      write_reg(CFG_CAL_FRAMES, run_tab[p][7:0]);
      write_reg(CFG_MAJORITY, maj_tab[p][7:0]);
      if (p < 3) begin
        send_idle_pct = 14;
        recv_idle_pct = 65;
      end else if (p < 6) begin
        send_idle_pct = 65;
        recv_idle_pct = 14;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < per_phase; i++) begin
        // Once, let the block empty completely part way through a phase.
        if (p == 4 && i == per_phase / 2) wait_drained();
        push_random_frame();
      end
      wait_drained();
    end

    repeat (NUM_CHANNELS + 6) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
src/lsac_pkg.sv
src/lsac_cell.sv
src/lsac_run_ctrl.sv
src/line_sensor_array_classifier_core.sv
verif/tb.sv
